@@ rtl/slfr_pkg.sv @@
package slfr_pkg;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned ADDR_OUT_W = 9;
  localparam int unsigned FLEN_W     = 7;
  localparam int unsigned COUNT_W    = 8;

  localparam logic [IN_DATA_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [IN_DATA_W-1:0] SYNC_SECOND = 8'h55;

  localparam logic [COUNT_W-1:0] SECOND_POS = 8'd1;
  localparam logic [COUNT_W-1:0] LENGTH_POS = 8'd4;

  typedef struct packed {
    logic                  dropped;
    logic [FLEN_W-1:0]     frame_length;
    logic [ADDR_OUT_W-1:0] frame_start;
    logic [ADDR_OUT_W-1:0] write_address;
  } result_t;

endpackage

@@ rtl/sync_length_frame_receiver.sv @@
// Length-prefixed frame receiver.
// The slave channel (s_axis_*) takes one received byte per transaction. The
// master channel (m_axis_*) returns exactly one transaction per byte: the
// buffer address at which the byte is to be stored, and, when the byte ends a
// frame, the frame's start address and total length. m_axis_tlast is high on
// the byte that completes a valid frame.
// A frame opens with 0xAA; once the header is in, its second byte must be
// 0x55 and its fifth byte gives the body length, which must not exceed
// BODY_MAX. Otherwise the partial frame is discarded and dropped is set.
// Each accepted byte's result is registered. One byte is taken per cycle
// while the result register can be emptied: all the decoding sits between
// the input port and the result register, and the byte counter and running
// address are updated in the same cycle.
// The result register holds while m_axis_tvalid is high and m_axis_tready is
// low; a new byte is accepted only if the register is empty or being emptied.
// Reset clears the counters and returns the write position to the buffer
// start; no result is pending afterwards.
module sync_length_frame_receiver #(
  parameter int unsigned BUFFER_BYTES   = 512,
  parameter int unsigned HEADER_BYTES   = 6,
  parameter int unsigned OVERHEAD_BYTES = 8,
  parameter int unsigned BODY_MAX       = 56
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // rx_byte[7:0]
  input  logic [slfr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // write_address[8:0], frame_start[17:9], frame_length[24:18], dropped[25],
  // zeros[31:26]
  output logic [slfr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // frame_done
  output logic                              m_axis_tlast
);
  import slfr_pkg::*;

  localparam int unsigned AW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int unsigned SUM_W = ((AW > COUNT_W) ? AW : COUNT_W) + 1;

  logic [COUNT_W-1:0]   byte_count, byte_count_next;
  logic [IN_DATA_W-1:0] body_length, body_length_next;
  logic [IN_DATA_W-1:0] second_byte, second_byte_next;
  logic [IN_DATA_W-1:0] fifth_byte, fifth_byte_next;
  logic [AW-1:0]        write_position, write_position_next;
  logic [AW-1:0]        cur_addr, cur_addr_next;

  logic                 accept;
  logic [COUNT_W-1:0]   count_inc;
  logic [IN_DATA_W-1:0] second_eff;
  logic [IN_DATA_W-1:0] body_eff;
  logic [SUM_W-1:0]     wp_sum;
  logic [AW-1:0]        addr_inc;
  logic                 done;
  logic                 drop;
  result_t              res, res_q;
  logic                 done_q;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign count_inc  = byte_count + COUNT_W'(1);
  assign second_eff = (byte_count == SECOND_POS) ? s_axis_tdata : second_byte;
  assign wp_sum     = SUM_W'(write_position) + SUM_W'(count_inc);
  assign addr_inc   = (cur_addr == AW'(BUFFER_BYTES - 1)) ? '0 : cur_addr + AW'(1);

  always_comb begin
    byte_count_next     = byte_count;
    body_length_next    = body_length;
    second_byte_next    = second_byte;
    fifth_byte_next     = fifth_byte;
    write_position_next = write_position;
    cur_addr_next       = cur_addr;
    body_eff            = body_length;
    done                = 1'b0;
    drop                = 1'b0;

    if (byte_count == '0 && s_axis_tdata != SYNC_FIRST) begin
      body_length_next = '0;
    end else begin
      second_byte_next = second_eff;
      if (byte_count == LENGTH_POS) begin
        fifth_byte_next = s_axis_tdata;
      end
      byte_count_next = count_inc;
      cur_addr_next   = (count_inc == '0) ? write_position : addr_inc;

      if (count_inc == COUNT_W'(HEADER_BYTES)) begin
        body_eff = (byte_count == LENGTH_POS) ? s_axis_tdata : fifth_byte;
      end
      body_length_next = body_eff;

      if (count_inc == COUNT_W'(HEADER_BYTES) && second_eff != SYNC_SECOND) begin
        drop = 1'b1;
      end else if (body_eff > IN_DATA_W'(BODY_MAX)) begin
        drop = 1'b1;
      end else if ({1'b0, count_inc} ==
                   (COUNT_W+1)'(body_eff) + (COUNT_W+1)'(OVERHEAD_BYTES)) begin
        done            = 1'b1;
        byte_count_next = '0;
        if (wp_sum >= SUM_W'(BUFFER_BYTES)) begin
          write_position_next = '0;
        end else begin
          write_position_next = AW'(wp_sum);
        end
        cur_addr_next = write_position_next;
      end

      if (drop) begin
        byte_count_next  = '0;
        body_length_next = '0;
        cur_addr_next    = write_position;
      end
    end

    res.write_address = ADDR_OUT_W'(cur_addr);
    res.frame_start   = done ? ADDR_OUT_W'(write_position) : '0;
    res.frame_length  = done ? FLEN_W'(count_inc) : '0;
    res.dropped       = drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      body_length    <= '0;
      second_byte    <= '0;
      fifth_byte     <= '0;
      write_position <= '0;
      cur_addr       <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (accept) begin
        byte_count     <= byte_count_next;
        body_length    <= body_length_next;
        second_byte    <= second_byte_next;
        fifth_byte     <= fifth_byte_next;
        write_position <= write_position_next;
        cur_addr       <= cur_addr_next;
        m_axis_tvalid  <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q  <= res;
      done_q <= done;
    end
  end

  assign m_axis_tdata = OUT_DATA_W'(res_q);
  assign m_axis_tlast = done_q;

  // When no frame is in progress, the running address equals the frame start.
  a_addr_tracks_count: assert property (@(posedge clk) disable iff (rst)
    byte_count == '0 |-> cur_addr == write_position)
    else $error("running address does not match frame start");

  a_wp_in_buffer: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(write_position) < SUM_W'(BUFFER_BYTES))
    else $error("write position beyond buffer");

  a_done_not_dropped: assert property (@(posedge clk) disable iff (rst)
    accept && done |-> !drop)
    else $error("frame both completed and dropped");

  a_done_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && (done || drop) |=> byte_count == '0)
    else $error("byte count not cleared after frame end");

endmodule

@@ tb/sync_length_frame_receiver_tb.sv @@
module sync_length_frame_receiver_tb;
  import slfr_pkg::*;

  localparam int BUF_BYTES   = 512;
  localparam int HDR_BYTES   = 6;
  localparam int OVH_BYTES   = 8;
  localparam int BODY_LIMIT  = 56;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 4;
  localparam int PHASE_BYTES = 300;
  localparam int ROW_COUNT   = 22;

  typedef struct packed {
    logic [ADDR_OUT_W-1:0] write_address;
    logic                  frame_done;
    logic [ADDR_OUT_W-1:0] frame_start;
    logic [FLEN_W-1:0]     frame_length;
    logic                  dropped;
  } slot_t;

  typedef struct packed {
    logic [IN_DATA_W-1:0] data;
    logic                 fixed;
    slot_t                want;
  } stim_row_t;

  localparam slot_t NO_SLOT = '0;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  logic                  cur_fixed = 1'b0;
  slot_t                 cur_want = '0;
  int                    src_idle_pct = 22;
  int                    sink_idle_pct = 58;
  int                    mismatch_count = 0;
  int                    stall_cycles = 0;

  logic [COUNT_W-1:0]    rx_count = '0;
  logic [7:0]            body_len = '0;
  logic [7:0]            second_seen = '0;
  logic [7:0]            fifth_seen = '0;
  int unsigned           frame_base = 0;

  slot_t                 pending_slots[$];
  slot_t                 predicted;
  slot_t                 expected_slot;
  result_t               got_res;
  stim_row_t             directed_rows [ROW_COUNT];

  sync_length_frame_receiver #(
    .BUFFER_BYTES  (BUF_BYTES),
    .HEADER_BYTES  (HDR_BYTES),
    .OVERHEAD_BYTES(OVH_BYTES),
    .BODY_MAX      (BODY_LIMIT)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= rst ? 1'b0 : ($urandom_range(0, 99) >= sink_idle_pct);
  end

  function automatic slot_t slot_of(input int addr, input int done, input int start,
                                    input int len, input int drop);
    slot_t s;
    s.write_address = ADDR_OUT_W'(addr);
    s.frame_done    = done[0];
    s.frame_start   = ADDR_OUT_W'(start);
    s.frame_length  = FLEN_W'(len);
    s.dropped       = drop[0];
    return s;
  endfunction

  // Works out where a received byte lands and what it does to the frame in progress.
  function automatic slot_t place_byte(input logic [IN_DATA_W-1:0] b);
    slot_t              s;
    logic [COUNT_W-1:0] n;
    s = '0;
    s.write_address = ADDR_OUT_W'((frame_base + rx_count) % BUF_BYTES);
    if (rx_count == '0 && b != SYNC_FIRST) begin
      rx_count = '0;
      body_len = '0;
      return s;
    end
    if (rx_count == SECOND_POS) second_seen = b;
    if (rx_count == LENGTH_POS) fifth_seen = b;
    n = rx_count + 1'b1;
    rx_count = n;
    if (n == HDR_BYTES) begin
      if (second_seen != SYNC_SECOND) begin
        rx_count = '0;
        body_len = '0;
        s.dropped = 1'b1;
        return s;
      end
      body_len = fifth_seen;
    end
    if (body_len > BODY_LIMIT) begin
      rx_count = '0;
      body_len = '0;
      s.dropped = 1'b1;
      return s;
    end
    if (int'(n) == int'(body_len) + OVH_BYTES) begin
      s.frame_done   = 1'b1;
      s.frame_start  = ADDR_OUT_W'(frame_base);
      s.frame_length = FLEN_W'(n);
      frame_base     = frame_base + n;
      if (frame_base >= BUF_BYTES) frame_base = 0;
      rx_count = '0;
    end
    return s;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_count = '0;
      body_len = '0;
      second_seen = '0;
      fifth_seen = '0;
      frame_base = 0;
      stall_cycles = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = place_byte(s_axis_tdata);
        pending_slots.push_back(cur_fixed ? cur_want : predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = m_axis_tdata[$bits(result_t)-1:0];
        if (pending_slots.size() == 0) begin
          flag_mismatch("unexpected transaction, write_address",
                        32'(got_res.write_address), 0);
        end else begin
          expected_slot = pending_slots.pop_front();
          if (got_res.write_address != expected_slot.write_address)
            flag_mismatch("write_address", 32'(got_res.write_address),
                          32'(expected_slot.write_address));
          if (m_axis_tlast != expected_slot.frame_done)
            flag_mismatch("frame_done", 32'(m_axis_tlast), 32'(expected_slot.frame_done));
          if (got_res.frame_start != expected_slot.frame_start)
            flag_mismatch("frame_start", 32'(got_res.frame_start),
                          32'(expected_slot.frame_start));
          if (got_res.frame_length != expected_slot.frame_length)
            flag_mismatch("frame_length", 32'(got_res.frame_length),
                          32'(expected_slot.frame_length));
          if (got_res.dropped != expected_slot.dropped)
            flag_mismatch("dropped", 32'(got_res.dropped), 32'(expected_slot.dropped));
          if (m_axis_tdata[OUT_DATA_W-1:$bits(result_t)] != '0)
            flag_mismatch("tdata padding",
                          32'(m_axis_tdata[OUT_DATA_W-1:$bits(result_t)]), 0);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic drive_rx_byte(input logic [IN_DATA_W-1:0] b, input logic fixed,
                               input slot_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    cur_fixed     <= fixed;
    cur_want      <= want;
    @(posedge clk);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_slots.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed frames with random content; some frames carry a bad second
  // byte or an oversized body, and stray non-sync bytes fall between frames.
  task automatic send_random_frame(output int sent);
    int                   pick;
    int                   body;
    logic [IN_DATA_W-1:0] second;
    logic [IN_DATA_W-1:0] b;
    sent = 0;
    if ($urandom_range(0, 99) < 10) begin
      b = IN_DATA_W'($urandom_range(0, 255));
      if (b == SYNC_FIRST) b = ~b;
      drive_rx_byte(b, 1'b0, NO_SLOT);
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55)      body = $urandom_range(0, 8);
    else if (pick < 80) body = $urandom_range(9, BODY_LIMIT - 1);
    else if (pick < 88) body = BODY_LIMIT;
    else if (pick < 95) body = $urandom_range(BODY_LIMIT + 1, 255);
    else                body = 255;
    second = SYNC_SECOND;
    if ($urandom_range(0, 99) < 8) begin
      second = IN_DATA_W'($urandom_range(0, 255));
      if (second == SYNC_SECOND) second = ~second;
    end
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (i == 0)               b = SYNC_FIRST;
      else if (i == SECOND_POS) b = second;
      else if (i == LENGTH_POS) b = body[7:0];
      else                      b = IN_DATA_W'($urandom_range(0, 255));
      drive_rx_byte(b, 1'b0, NO_SLOT);
    end
    sent = HDR_BYTES;
    if (second == SYNC_SECOND && body <= BODY_LIMIT) begin
      repeat (body + OVH_BYTES - HDR_BYTES)
        drive_rx_byte(IN_DATA_W'($urandom_range(0, 255)), 1'b0, NO_SLOT);
      sent += body + OVH_BYTES - HDR_BYTES;
    end
  endtask

  initial begin
    int sent;
    int phase_bytes;
    directed_rows = '{
      '{8'h00,       1'b1, slot_of(0, 0, 0, 0, 0)},
      '{8'hFF,       1'b1, slot_of(0, 0, 0, 0, 0)},
      '{SYNC_FIRST,  1'b1, slot_of(0, 0, 0, 0, 0)},
      '{SYNC_SECOND, 1'b0, NO_SLOT},
      '{8'h00,       1'b0, NO_SLOT},
      '{8'hFF,       1'b0, NO_SLOT},
      '{8'h00,       1'b0, NO_SLOT},
      '{8'h5A,       1'b0, NO_SLOT},
      '{8'h3C,       1'b0, NO_SLOT},
      '{8'hC3,       1'b1, slot_of(7, 1, 0, 8, 0)},
      '{SYNC_FIRST,  1'b0, NO_SLOT},
      '{8'h54,       1'b0, NO_SLOT},
      '{8'h12,       1'b0, NO_SLOT},
      '{8'h34,       1'b0, NO_SLOT},
      '{8'h00,       1'b0, NO_SLOT},
      '{8'h56,       1'b1, slot_of(13, 0, 0, 0, 1)},
      '{SYNC_FIRST,  1'b0, NO_SLOT},
      '{SYNC_SECOND, 1'b0, NO_SLOT},
      '{8'h00,       1'b0, NO_SLOT},
      '{8'h00,       1'b0, NO_SLOT},
      '{8'h39,       1'b0, NO_SLOT},
      '{8'h77,       1'b1, slot_of(13, 0, 0, 0, 1)}
    };
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      drive_rx_byte(directed_rows[i].data, directed_rows[i].fixed, directed_rows[i].want);
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 22 : (phase == 1) ? 58 : 0;
      sink_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 22 : 0;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        send_random_frame(sent);
        phase_bytes += sent;
      end
      drain_results();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
